// File: hdl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// shared widths and default parameter values for the dda line rasterizer
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;

  localparam int CANVAS_SIZE_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;

endpackage

// File: hdl/dda_divider.sv
// ----------------------------------------------------------------------------
// dda_divider
// restoring divider, one quotient bit per cycle, for the slope computation
// ----------------------------------------------------------------------------
module dda_divider
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [COORD_W+FRAC_BITS-1:0] dividend_i,
  input  logic [COORD_W-1:0]           divisor_i,
  output logic                         done_o,
  output logic [FRAC_BITS:0]           quotient_o
);

  localparam int DvdW = COORD_W + FRAC_BITS;
  localparam int CntW = $clog2(DvdW + 1);

  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DvdW-1:0]    work_q;
  logic [COORD_W-1:0] rem_q;
  logic [COORD_W-1:0] divisor_q;

  logic [COORD_W:0]   rem_sh;
  logic               ge;
  logic [COORD_W:0]   diff;

  assign rem_sh = {rem_q, work_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, divisor_q};
  assign diff   = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      work_q <= {work_q[DvdW-2:0], ge};
      rem_q  <= ge ? diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q[FRAC_BITS:0];

endmodule

// File: hdl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// steps a fixed-point minor coordinate along the major axis of a segment
// ----------------------------------------------------------------------------
// usage:
//   the input channel takes one segment beat (two endpoints and a color)
//   while in_stall_o is low; it stays high until the segment's last pixel
//   has been taken, so one segment is in work at a time.
//   the output channel gives one beat per pixel, major coordinate rising,
//   with last_pixel_o set on the final pixel of the segment.
//   timing: the segment is taken in idle, then the restoring divider
//   computes the slope (skipped for a zero-length segment), a load state
//   registers the first pixel, then one pixel per cycle follows while
//   out_stall_i is low. the divider's one bit per cycle sets the setup
//   time, the accumulator step sets the pixel rate.
//   a stalled output beat holds its payload and the stepper waits.
//   reset returns the block to idle with no output beat pending.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int CANVAS_SIZE = CANVAS_SIZE_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] x_start_i,
  input  logic [COORD_W-1:0] y_start_i,
  input  logic [COORD_W-1:0] x_end_i,
  input  logic [COORD_W-1:0] y_end_i,
  input  logic [COLOR_W-1:0] red_in_i,
  input  logic [COLOR_W-1:0] green_in_i,
  input  logic [COLOR_W-1:0] blue_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] pixel_x_o,
  output logic [COORD_W-1:0] pixel_y_o,
  output logic [COLOR_W-1:0] red_out_o,
  output logic [COLOR_W-1:0] green_out_o,
  output logic [COLOR_W-1:0] blue_out_o,
  output logic               last_pixel_o
);

  localparam int SlpW     = FRAC_BITS + 2;
  localparam int AccW     = FRAC_BITS + COORD_W + 1;
  localparam int CoordMax = CANVAS_SIZE - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_EMIT
  } state_e;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    if (int'(v) > CoordMax) begin
      return COORD_W'(CoordMax);
    end
    return v;
  endfunction

  state_e state_q;

  logic                     x_major_q;
  logic                     neg_q;
  logic [COORD_W-1:0]       maj_q;
  logic [COORD_W-1:0]       remain_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [SlpW-1:0]   slope_q;
  logic [COLOR_W-1:0]       red_q;
  logic [COLOR_W-1:0]       green_q;
  logic [COLOR_W-1:0]       blue_q;

  logic                     out_valid_q;
  logic [COORD_W-1:0]       pixel_x_q;
  logic [COORD_W-1:0]       pixel_y_q;
  logic                     last_q;

  // segment setup
  logic               accept;
  logic [COORD_W:0]   dx;
  logic [COORD_W:0]   dy;
  logic [COORD_W-1:0] adx;
  logic [COORD_W-1:0] ady;
  logic               x_major;
  logic [COORD_W-1:0] maj0_r;
  logic [COORD_W-1:0] maj1_r;
  logic [COORD_W-1:0] min0_r;
  logic [COORD_W-1:0] min1_r;
  logic               swap;
  logic [COORD_W-1:0] maj0;
  logic [COORD_W-1:0] maj1;
  logic [COORD_W-1:0] min0;
  logic [COORD_W-1:0] min1;
  logic [COORD_W-1:0] span;
  logic [COORD_W:0]   dmin;
  logic [COORD_W:0]   dmin_neg;
  logic [COORD_W-1:0] mag;

  // divider
  logic               div_start;
  logic               div_done;
  logic [FRAC_BITS:0] quotient;

  // pixel stepping
  logic               push;
  logic [COORD_W-1:0] minor;
  logic [COORD_W-1:0] maj_c;
  logic [COORD_W-1:0] min_c;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    dx       = {1'b0, x_end_i} - {1'b0, x_start_i};
    dy       = {1'b0, y_end_i} - {1'b0, y_start_i};
    adx      = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady      = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    x_major  = adx > ady;
    maj0_r   = x_major ? x_start_i : y_start_i;
    maj1_r   = x_major ? x_end_i   : y_end_i;
    min0_r   = x_major ? y_start_i : x_start_i;
    min1_r   = x_major ? y_end_i   : x_end_i;
    swap     = maj0_r > maj1_r;
    maj0     = swap ? maj1_r : maj0_r;
    maj1     = swap ? maj0_r : maj1_r;
    min0     = swap ? min1_r : min0_r;
    min1     = swap ? min0_r : min1_r;
    span     = maj1 - maj0;
    dmin     = {1'b0, min1} - {1'b0, min0};
    dmin_neg = -dmin;
    mag      = dmin[COORD_W] ? dmin_neg[COORD_W-1:0] : dmin[COORD_W-1:0];
  end

  assign div_start = accept && (span != '0);

  dda_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, {FRAC_BITS{1'b0}}}),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign push = (state_q == ST_LOAD) ||
                ((state_q == ST_EMIT) && !out_stall_i && !last_q);

  always_comb begin
    minor = acc_q[AccW-1] ? '0 : acc_q[FRAC_BITS+COORD_W-1:FRAC_BITS];
    maj_c = clamp_coord(maj_q);
    min_c = clamp_coord(minor);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (span != '0) ? ST_DIV : ST_LOAD;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q     <= ST_EMIT;
          out_valid_q <= 1'b1;
        end
        ST_EMIT: begin
          if (!out_stall_i && last_q) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_major_q <= x_major;
      neg_q     <= dmin[COORD_W];
      maj_q     <= maj0;
      remain_q  <= span;
      acc_q     <= {1'b0, min0, {FRAC_BITS{1'b0}}};
      slope_q   <= '0;
      red_q     <= red_in_i;
      green_q   <= green_in_i;
      blue_q    <= blue_in_i;
    end
    if ((state_q == ST_DIV) && div_done) begin
      slope_q <= neg_q ? -{1'b0, quotient} : {1'b0, quotient};
    end
    if (push) begin
      pixel_x_q <= x_major_q ? maj_c : min_c;
      pixel_y_q <= x_major_q ? min_c : maj_c;
      last_q    <= (remain_q == '0);
      remain_q  <= remain_q - 1'b1;
      maj_q     <= maj_q + 1'b1;
      acc_q     <= acc_q + AccW'(slope_q);
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign last_pixel_o = last_q;

endmodule
